[rtl/core/sal_pkg.sv]
package sal_pkg;

  // Default list depth
  localparam int unsigned CAPACITY_DEF = 16;

  // Field widths of the stream words
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_END   = 3'd1,
    FN_INS_POS   = 3'd2,
    FN_REM_FRONT = 3'd3,
    FN_REM_END   = 3'd4,
    FN_REM_POS   = 3'd5,
    FN_READ      = 3'd6
  } func_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic ins;   // open a slot at the index, later cells take the left neighbor
    logic rem;   // close the slot at the index, later cells take the right neighbor
  } sal_ctl_t;

endpackage

[rtl/core/sal_cell.sv]
module sal_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 4
) (
  input  logic                       clk,
  input  logic                       accept,
  input  sal_pkg::sal_ctl_t          ctl,
  input  logic [IW-1:0]              at,
  input  logic [sal_pkg::WORD_W-1:0] word,
  input  logic [sal_pkg::WORD_W-1:0] left,
  input  logic [sal_pkg::WORD_W-1:0] right,
  input  logic [sal_pkg::WORD_W-1:0] rd_in,
  output logic [sal_pkg::WORD_W-1:0] rd_out,
  output logic [sal_pkg::WORD_W-1:0] entry
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [sal_pkg::WORD_W-1:0] entry_r;
  logic [sal_pkg::WORD_W-1:0] entry_nxt;

  // Next entry: hold, take a neighbor, or take the new word
  always_comb begin
    entry_nxt = entry_r;
    if (accept && ctl.ins) begin
      if (MY_IDX > at) begin
        entry_nxt = left;
      end else if (MY_IDX == at) begin
        entry_nxt = word;
      end
    end else if (accept && ctl.rem && (MY_IDX >= at)) begin
      entry_nxt = right;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // Read path: the addressed cell joins its entry into the chain
  assign rd_out = rd_in | ((MY_IDX == at) ? entry_r : '0);
  assign entry  = entry_r;

endmodule

[rtl/core/sal_ctrl.sv]
module sal_ctrl #(
  parameter int unsigned CAPACITY = sal_pkg::CAPACITY_DEF,
  parameter int unsigned IW       = 4,
  parameter int unsigned FW       = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [sal_pkg::FUNC_W-1:0]   func,
  input  logic [sal_pkg::POS_W-1:0]    position,
  output sal_pkg::sal_ctl_t            ctl,
  output logic [IW-1:0]                at,
  output logic                         read_ok,
  output sal_pkg::status_t             status,
  output logic [sal_pkg::COUNT_W-1:0]  count
);

  localparam int unsigned CW = (FW > sal_pkg::POS_W) ? FW : sal_pkg::POS_W;

  logic [FW-1:0] fill_r;
  logic [FW-1:0] fill_nxt;
  logic [CW-1:0] pos_c;
  logic [CW-1:0] fill_c;
  logic [31:0]   fill_w;
  logic          full;
  logic          empty;

  assign pos_c  = CW'(position);
  assign fill_c = CW'(fill_r);
  assign full   = (fill_r == FW'(CAPACITY));
  assign empty  = (fill_r == '0);

  // Decode the operation against the current fill
  always_comb begin
    ctl      = '0;
    at       = '0;
    read_ok  = 1'b0;
    status   = sal_pkg::ST_OK;
    fill_nxt = fill_r;
    unique case (sal_pkg::func_t'(func))
      sal_pkg::FN_INS_FRONT: begin
        if (full) begin
          status = sal_pkg::ST_FULL;
        end else begin
          ctl.ins  = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end
      sal_pkg::FN_INS_END: begin
        if (full) begin
          status = sal_pkg::ST_FULL;
        end else begin
          ctl.ins  = 1'b1;
          at       = fill_c[IW-1:0];
          fill_nxt = fill_r + 1'b1;
        end
      end
      sal_pkg::FN_INS_POS: begin
        if (full) begin
          status = sal_pkg::ST_FULL;
        end else if (pos_c > fill_c) begin
          status = sal_pkg::ST_BADPOS;
        end else begin
          ctl.ins  = 1'b1;
          at       = pos_c[IW-1:0];
          fill_nxt = fill_r + 1'b1;
        end
      end
      sal_pkg::FN_REM_FRONT: begin
        if (empty) begin
          status = sal_pkg::ST_EMPTY;
        end else begin
          ctl.rem  = 1'b1;
          fill_nxt = fill_r - 1'b1;
        end
      end
      sal_pkg::FN_REM_END: begin
        if (empty) begin
          status = sal_pkg::ST_EMPTY;
        end else begin
          fill_nxt = fill_r - 1'b1;
        end
      end
      sal_pkg::FN_REM_POS: begin
        if (empty) begin
          status = sal_pkg::ST_EMPTY;
        end else if (pos_c >= fill_c) begin
          status = sal_pkg::ST_BADPOS;
        end else begin
          ctl.rem  = 1'b1;
          at       = pos_c[IW-1:0];
          fill_nxt = fill_r - 1'b1;
        end
      end
      sal_pkg::FN_READ: begin
        if (empty) begin
          status = sal_pkg::ST_EMPTY;
        end else if (pos_c >= fill_c) begin
          status = sal_pkg::ST_BADPOS;
        end else begin
          read_ok = 1'b1;
          at      = pos_c[IW-1:0];
        end
      end
      default: begin
        // unused code: no operation
      end
    endcase
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  assign fill_w = 32'(fill_nxt);
  assign count  = fill_w[sal_pkg::COUNT_W-1:0];

endmodule

[rtl/core/shifting_array_list.sv]
// The result word of an accepted word is registered in the output register on acceptance.
// One word per cycle while the output register is free or being emptied; every cell of the
// row shifts in the same cycle, so the next word may follow at once.
// Reset (rst_n low, synchronous) empties the list and drops the pending result;
// list entries themselves are not cleared.
module shifting_array_list #(
  parameter int unsigned CAPACITY = sal_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // func[2:0], position[7:3], value[39:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[1:0], read_value[33:2], count[38:34], zero[39]
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned WW = sal_pkg::WORD_W;

  logic                        accept;
  logic [sal_pkg::FUNC_W-1:0]  func;
  logic [sal_pkg::POS_W-1:0]   position;
  logic [WW-1:0]               value;
  sal_pkg::sal_ctl_t           ctl;
  logic [IW-1:0]               at;
  logic                        read_ok;
  sal_pkg::status_t            status;
  logic [sal_pkg::COUNT_W-1:0] count;
  logic [WW-1:0]               ent [CAPACITY];
  logic [WW-1:0]               rd  [CAPACITY+1];

  logic                        out_valid_r;
  logic [39:0]                 out_data_r;

  // Input word fields
  assign func     = in_tdata[2:0];
  assign position = in_tdata[7:3];
  assign value    = in_tdata[39:8];

  // Take a word whenever the output register is free or being emptied
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  sal_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .FW       (FW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .func     (func),
    .position (position),
    .ctl      (ctl),
    .at       (at),
    .read_ok  (read_ok),
    .status   (status),
    .count    (count)
  );

  // Row of entry cells
  assign rd[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WW-1:0] left;
    logic [WW-1:0] right;

    if (i == 0) begin : g_first
      assign left = value;
    end else begin : g_mid_l
      assign left = ent[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = ent[i];
    end else begin : g_mid_r
      assign right = ent[i+1];
    end

    sal_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk    (clk),
      .accept (accept),
      .ctl    (ctl),
      .at     (at),
      .word   (value),
      .left   (left),
      .right  (right),
      .rd_in  (rd[i]),
      .rd_out (rd[i+1]),
      .entry  (ent[i])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {1'b0, count, (read_ok ? rd[CAPACITY] : '0), status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
